// ----- rtl/ctnms_pkg.sv -----
// Shared constants for the corner keypoint suppression block: field widths,
// request and action codes, register indexes and reset values.
// No dependencies.
package ctnms_pkg;

    localparam int PIX_W   = 11;  // coordinate width on the stream ports
    localparam int RESP_W  = 8;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;
    localparam int REQ_W   = 2;
    localparam int ACT_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 11;

    // Request kinds carried on s_tuser.
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Result kinds carried on m_tuser.
    localparam logic [ACT_W-1:0] ACT_BELOW      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPENDED   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACED   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUPPRESSED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROPPED    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DONE       = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESPONSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_DIST = 1'd1;

    localparam logic [RESP_W-1:0] MIN_RESPONSE_RST = 8'd100;
    localparam logic [CFG_W-1:0]  OVERLAP_DIST_RST = 16'd36;

endpackage

// ----- rtl/corner_threshold_greedy_nms.sv -----
// Top level of the corner keypoint suppression block: keypoint store,
// scan sequencer with one shared squaring unit, and output register.
// Depends on ctnms_pkg.
//
// Usage: send one request per s_ beat. The kind is on s_tuser (pixel,
// clear list, read entry). Every request gives exactly one m_ beat with
// the action on m_tuser and slot, entry and point count on m_tdata.
// Configuration (threshold, overlap bound) is written on the cfg_ port
// while no request is in flight.
//
// Sequencing: s_tready is high only while the sequencer is idle, so one
// request is worked on at a time. Clear, unused kinds and pixels at or
// below threshold go straight to the emit state; a read first reads the
// store, unless the index is past the point count. A candidate pixel scans
// the stored points in slot order, in the states dx, dy and compare per
// point (the squaring unit is used for dx and then dy, then the sum is
// compared); then a final step appends, suppresses or drops it. The
// scan stops at the first weaker overlapping point and skips the final step.
// The result sits in an output register; if the receiver stalls, the next
// result waits in its final state until that register drains.
// Reset empties the list (contents of the store stay undefined) and loads
// the register defaults.
module corner_threshold_greedy_nms
    import ctnms_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [10:0] pix_x, [21:11] pix_y, [29:22] pix_response, [37:30] read_index
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]       s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] slot, [18:8] entry_x, [29:19] entry_y, [37:30] entry_response,
    // [46:38] point_count
    output logic [M_TDATA_W-1:0]   m_tdata,
    // [2:0] action
    output logic [ACT_W-1:0]       m_tuser,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW  = $clog2(MAX_POINTS + 1);
    localparam int ENTW  = 2 * CW + RESP_W;
    localparam int SQW   = 2 * CW;
    localparam int DW    = (2 * CW + 1 > CFG_W) ? 2 * CW + 1 : CFG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DX   = 3'd1;
    localparam logic [2:0] ST_DY   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_RDO  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    // Input fields.
    logic [PIX_W-1:0]  in_x, in_y;
    logic [RESP_W-1:0] in_r;
    logic [SLOT_W-1:0] in_ridx;
    assign in_x    = s_tdata[10:0];
    assign in_y    = s_tdata[21:11];
    assign in_r    = s_tdata[29:22];
    assign in_ridx = s_tdata[37:30];

    logic [2:0]        state_reg;
    logic [CNTW-1:0]   count_reg;
    logic [AW-1:0]     idx_reg;
    logic              ovl_reg;
    logic [CW-1:0]     cand_x_reg, cand_y_reg;
    logic [RESP_W-1:0] cand_r_reg;
    logic [SQW-1:0]    sum_reg, sq_reg;
    logic [RESP_W-1:0] min_resp_reg;
    logic [CFG_W-1:0]  dist_reg;

    logic [ACT_W-1:0]  res_act_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [PIX_W-1:0]  res_x_reg, res_y_reg;
    logic [RESP_W-1:0] res_r_reg;

    logic              m_tvalid_reg;
    logic [ACT_W-1:0]  m_act_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [PIX_W-1:0]  m_x_reg, m_y_reg;
    logic [RESP_W-1:0] m_r_reg;
    logic [COUNT_W-1:0] m_cnt_reg;

    // Keypoint store, packed as {response, y, x}.
    logic [ENTW-1:0]   mem [MAX_POINTS];
    logic [ENTW-1:0]   rd_data_reg;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [ENTW-1:0]   wr_data;

    logic [CW-1:0]     ent_x, ent_y;
    logic [RESP_W-1:0] ent_r;
    assign ent_x = rd_data_reg[CW-1:0];
    assign ent_y = rd_data_reg[2*CW-1:CW];
    assign ent_r = rd_data_reg[ENTW-1:2*CW];

    logic accept, cand_hit, read_ok, out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign cand_hit = (in_r > min_resp_reg);
    assign read_ok  = (32'(in_ridx) < 32'(count_reg));
    assign out_free = !m_tvalid_reg || m_tready;

    // Shared squaring unit: |a - b|^2 on the x pair in ST_DX, else the y pair.
    logic [CW-1:0]  op_a, op_b, op_diff;
    logic [SQW-1:0] sq_out;
    always_comb begin
        if (state_reg == ST_DX) begin
            op_a = cand_x_reg;
            op_b = ent_x;
        end else begin
            op_a = cand_y_reg;
            op_b = ent_y;
        end
        op_diff = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
        sq_out  = SQW'(op_diff) * SQW'(op_diff);
    end

    logic [DW-1:0]   dist_sum;
    logic            overlap_now, replace_now, more_entries;
    logic [CNTW-1:0] idx_inc;
    assign dist_sum     = DW'(sum_reg) + DW'(sq_reg);
    assign overlap_now  = (dist_sum < DW'(dist_reg));
    assign replace_now  = overlap_now && (cand_r_reg > ent_r);
    assign idx_inc      = CNTW'(idx_reg) + CNTW'(1);
    assign more_entries = (idx_inc < count_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {cand_r_reg, cand_y_reg, cand_x_reg};
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == REQ_PIXEL && cand_hit && count_reg != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end else if (accept && s_tuser == REQ_READ && read_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(in_ridx);
                end
            end
            ST_CMP: begin
                if (replace_now) begin
                    wr_en = 1'b1;
                end else if (more_entries) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_inc);
                end
            end
            ST_FIN: begin
                if (!ovl_reg && 32'(count_reg) < 32'(MAX_POINTS)) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer and result path.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            min_resp_reg <= MIN_RESPONSE_RST;
            dist_reg     <= OVERLAP_DIST_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MIN_RESPONSE: min_resp_reg <= cfg_wdata[RESP_W-1:0];
                    CFG_OVERLAP_DIST: dist_reg     <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cand_x_reg   <= CW'(in_x);
                        cand_y_reg   <= CW'(in_y);
                        cand_r_reg   <= in_r;
                        idx_reg      <= '0;
                        ovl_reg      <= 1'b0;
                        res_x_reg    <= '0;
                        res_y_reg    <= '0;
                        res_r_reg    <= '0;
                        case (s_tuser)
                            REQ_PIXEL: begin
                                res_slot_reg <= '0;
                                if (!cand_hit) begin
                                    res_act_reg <= ACT_BELOW;
                                    state_reg   <= ST_EMIT;
                                end else if (count_reg != '0) begin
                                    res_act_reg <= ACT_DONE;
                                    state_reg   <= ST_DX;
                                end else begin
                                    res_act_reg <= ACT_DONE;
                                    state_reg   <= ST_FIN;
                                end
                            end
                            REQ_CLEAR: begin
                                count_reg    <= '0;
                                res_act_reg  <= ACT_DONE;
                                res_slot_reg <= '0;
                                state_reg    <= ST_EMIT;
                            end
                            REQ_READ: begin
                                res_act_reg  <= ACT_DONE;
                                res_slot_reg <= in_ridx;
                                if (read_ok) begin
                                    state_reg <= ST_RDO;
                                end else begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            default: begin
                                res_act_reg  <= ACT_DONE;
                                res_slot_reg <= '0;
                                state_reg    <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DX: begin
                    sum_reg   <= sq_out;
                    state_reg <= ST_DY;
                end
                ST_DY: begin
                    sq_reg    <= sq_out;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (replace_now) begin
                        res_act_reg  <= ACT_REPLACED;
                        res_slot_reg <= SLOT_W'(idx_reg);
                        state_reg    <= ST_EMIT;
                    end else begin
                        ovl_reg <= ovl_reg | overlap_now;
                        if (more_entries) begin
                            idx_reg   <= AW'(idx_inc);
                            state_reg <= ST_DX;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (ovl_reg) begin
                        res_act_reg <= ACT_SUPPRESSED;
                    end else if (32'(count_reg) < 32'(MAX_POINTS)) begin
                        res_act_reg  <= ACT_APPENDED;
                        res_slot_reg <= SLOT_W'(count_reg);
                        count_reg    <= count_reg + CNTW'(1);
                    end else begin
                        res_act_reg <= ACT_DROPPED;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_RDO: begin
                    res_x_reg <= PIX_W'(ent_x);
                    res_y_reg <= PIX_W'(ent_y);
                    res_r_reg <= ent_r;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_act_reg    <= res_act_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_x_reg      <= res_x_reg;
                        m_y_reg      <= res_y_reg;
                        m_r_reg      <= res_r_reg;
                        m_cnt_reg    <= COUNT_W'(count_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_act_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_r_reg, m_y_reg, m_x_reg, m_slot_reg};

endmodule

// ----- tb/nms_checker.sv -----
// Checker for the corner keypoint suppression block: keeps its own keypoint
// list, predicts one result per request beat and compares the result beats.
// Depends on ctnms_pkg.
module nms_checker
    import ctnms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [ACT_W-1:0]     m_tuser,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    output int                   n_pending,
    output int                   n_errors
);

    localparam int PRINT_LIMIT = 40;

    // Request fields as they sit in s_tdata, lowest field last.
    typedef struct packed {
        logic [SLOT_W-1:0] index;
        logic [RESP_W-1:0] resp;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  x;
    } pixel_req_t;

    // Result fields: action from m_tuser on top of the m_tdata fields.
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COUNT_W-1:0] count;
        logic [RESP_W-1:0]  resp;
        logic [PIX_W-1:0]   y;
        logic [PIX_W-1:0]   x;
        logic [SLOT_W-1:0]  slot;
    } nms_result_t;

    logic [PIX_W-1:0]  kp_x [MAX_POINTS_DEF];
    logic [PIX_W-1:0]  kp_y [MAX_POINTS_DEF];
    logic [RESP_W-1:0] kp_r [MAX_POINTS_DEF];
    int unsigned       kp_count;
    logic [RESP_W-1:0] min_resp;
    logic [CFG_W-1:0]  overlap_bound;

    nms_result_t pending_results [$];
    int          pending_count = 0;
    int          err_count = 0;

    assign n_pending = pending_count;
    assign n_errors  = err_count;

    task automatic report(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] checker: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want)
            report($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // Applies one request to the keypoint list and returns the result it gives.
    function automatic nms_result_t next_keypoint_result(input logic [REQ_W-1:0] kind,
                                                         input pixel_req_t rq);
        nms_result_t res;
        int unsigned dx, dy, hit;
        bit          overlap;
        res = '0;
        res.action = ACT_DONE;
        case (kind)
            REQ_PIXEL: begin
                if (rq.resp <= min_resp) begin
                    res.action = ACT_BELOW;
                end else begin
                    overlap = 1'b0;
                    hit = kp_count;
                    // The first overlapping point that is strictly weaker wins.
                    for (int i = 0; i < kp_count; i++) begin
                        dx = (rq.x > kp_x[i]) ? rq.x - kp_x[i] : kp_x[i] - rq.x;
                        dy = (rq.y > kp_y[i]) ? rq.y - kp_y[i] : kp_y[i] - rq.y;
                        if (dx * dx + dy * dy < overlap_bound) begin
                            overlap = 1'b1;
                            if (rq.resp > kp_r[i]) begin
                                hit = i;
                                break;
                            end
                        end
                    end
                    if (hit < kp_count) begin
                        kp_x[hit] = rq.x;
                        kp_y[hit] = rq.y;
                        kp_r[hit] = rq.resp;
                        res.action = ACT_REPLACED;
                        res.slot = SLOT_W'(hit);
                    end else if (overlap) begin
                        res.action = ACT_SUPPRESSED;
                    end else if (kp_count < MAX_POINTS_DEF) begin
                        kp_x[kp_count] = rq.x;
                        kp_y[kp_count] = rq.y;
                        kp_r[kp_count] = rq.resp;
                        res.action = ACT_APPENDED;
                        res.slot = SLOT_W'(kp_count);
                        kp_count++;
                    end else begin
                        res.action = ACT_DROPPED;
                    end
                end
            end
            REQ_CLEAR: begin
                kp_count = 0;
            end
            REQ_READ: begin
                res.slot = rq.index;
                if (rq.index < kp_count) begin
                    res.x = kp_x[rq.index];
                    res.y = kp_y[rq.index];
                    res.resp = kp_r[rq.index];
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(kp_count);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        nms_result_t want, got, pred;
        if (!aresetn) begin
            kp_count = 0;
            min_resp = MIN_RESPONSE_RST;
            overlap_bound = OVERLAP_DIST_RST;
            pending_results.delete();
        end else begin
            // A result beat always belongs to an earlier request, so it is
            // checked before the request beat of the same edge is queued.
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[COUNT_W+RESP_W+2*PIX_W+SLOT_W-1:0]};
                if (pending_results.size() == 0) begin
                    report($sformatf("result beat with no request outstanding, action %0d",
                                     m_tuser));
                end else begin
                    want = pending_results.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("slot", want.slot, got.slot);
                    check_field("entry_x", want.x, got.x);
                    check_field("entry_y", want.y, got.y);
                    check_field("entry_response", want.resp, got.resp);
                    check_field("point_count", want.count, got.count);
                end
            end
            if (s_tvalid && s_tready) begin
                pred = next_keypoint_result(s_tuser, s_tdata[$bits(pixel_req_t)-1:0]);
                pending_results = {pending_results, pred};
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MIN_RESPONSE: min_resp = cfg_wdata[RESP_W-1:0];
                    CFG_OVERLAP_DIST: overlap_bound = cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for corner_threshold_greedy_nms: clock, reset, request and
// configuration stimulus, random stalls on the result side and the verdict.
// Depends on ctnms_pkg, corner_threshold_greedy_nms and nms_checker.
module tb;
    import ctnms_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_ITEMS = 120;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ACT_W-1:0]     m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int n_pending;
    int n_errors;
    int cycle_count = 0;
    int ready_hold = 0;
    bit idle_on = 1'b1;

    corner_threshold_greedy_nms i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    nms_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_pending (n_pending),
        .n_errors  (n_errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: ready and stall stretches of random length, in random order.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!idle_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            ready_hold <= gap_len();
        end
    end

    // Called at a rising edge; returns at the edge where the beat was taken,
    // or after the gap that follows it.
    task automatic send_req(input logic [REQ_W-1:0] kind, input int x, y, r, idx);
        int g;
        s_tuser <= kind;
        s_tdata <= S_TDATA_W'({SLOT_W'(idx), RESP_W'(r), PIX_W'(y), PIX_W'(x)});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Waits until every request has produced its result beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
        @(posedge aclk);
    endtask

    task automatic set_config(input int thresh, input int bound);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_RESPONSE;
        cfg_wdata <= CFG_W'(RESP_W'(thresh));
        @(posedge aclk);
        cfg_index <= CFG_OVERLAP_DIST;
        cfg_wdata <= CFG_W'(bound);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pixels mostly land in a small window so that points overlap; the window
    // moves every few dozen beats. Clears keep the list short.
    task automatic random_phase(input int n_items, input int win);
        int wx, wy, pick;
        wx = 0;
        wy = 0;
        for (int k = 0; k < n_items; k++) begin
            if (k % 30 == 0) begin
                wx = $urandom_range(0, 2048 - win);
                wy = $urandom_range(0, 2048 - win);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 8)
                send_req(REQ_READ, $urandom, $urandom, $urandom, $urandom_range(0, 31));
            else if (pick < 10)
                send_req(REQ_READ, $urandom, $urandom, $urandom, $urandom);
            else if (pick == 10)
                send_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 20)
                send_req(REQ_PIXEL, $urandom, $urandom, $urandom, $urandom);
            else
                send_req(REQ_PIXEL, wx + $urandom_range(0, win - 1),
                         wy + $urandom_range(0, win - 1), $urandom, $urandom);
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings (threshold 100, bound 36).
        send_req(REQ_READ, 0, 0, 0, 0);           // read of an empty list
        send_req(REQ_PIXEL, 5, 5, 100, 0);        // response equal to the threshold
        send_req(REQ_PIXEL, 0, 0, 0, 0);
        send_req(REQ_PIXEL, 10, 10, 150, 0);
        send_req(REQ_PIXEL, 12, 11, 150, 0);      // equal response overlaps: suppressed
        send_req(REQ_PIXEL, 12, 11, 200, 0);      // stronger: replaces slot 0
        send_req(REQ_PIXEL, 2047, 2047, 255, 255);
        send_req(REQ_PIXEL, 0, 0, 101, 0);
        send_req(REQ_PIXEL, 0, 6, 255, 0);        // distance exactly at the bound
        send_req(REQ_PIXEL, 0, 5, 255, 0);        // first weaker overlap is replaced
        send_req(REQ_PIXEL, 0, 5, 254, 0);        // two stronger overlaps
        for (int i = 0; i < 5; i++)
            send_req(REQ_READ, 2047, 2047, 255, i);
        send_req(REQ_READ, 0, 0, 0, 255);         // read past the count
        send_req(REQ_UNUSED, 2047, 2047, 255, 255);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_READ, 0, 0, 0, 0);
        drain();

        set_config(255, 36);
        random_phase(60, 64);

        // Fill the list to the last slot and past it, back to back.
        idle_on = 1'b0;
        set_config(0, 0);
        for (int k = 0; k < MAX_POINTS_DEF + 6; k++)
            send_req(REQ_PIXEL, $urandom, $urandom, $urandom_range(1, 255), $urandom);
        drain();
        idle_on = 1'b1;
        set_config(0, 65535);
        repeat (8)
            send_req(REQ_PIXEL, $urandom, $urandom, $urandom, $urandom);
        send_req(REQ_READ, 0, 0, 0, 255);
        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        drain();

        set_config(0, 65535);
        random_phase(PHASE_ITEMS, 64);
        idle_on = 1'b0;
        set_config(100, 36);
        random_phase(PHASE_ITEMS, 48);
        idle_on = 1'b1;
        set_config($urandom, $urandom_range(0, 2000));
        random_phase(PHASE_ITEMS, 64);
        set_config(200, 400);
        random_phase(PHASE_ITEMS, 96);
        set_config(0, 1);
        random_phase(PHASE_ITEMS, 8);
        set_config($urandom, $urandom);
        random_phase(PHASE_ITEMS, 128);

        repeat (20) @(posedge aclk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
